>>> hw/rtl/cac_pkg.sv
// Shared types, codes and constants of the connection admission controller.
`timescale 1ns / 1ps
package cac_pkg;

   localparam int SLOT_COUNT_DEF      = 64;
   localparam int LIMITER_ENTRIES_DEF = 16;
   localparam int SLOT_LIMIT          = 64;

   localparam logic [16:0] COUNT_MAX = 17'h1FFFF;

   localparam logic [15:0] MAX_ATT_RST = 16'd100;
   localparam logic [19:0] WINDOW_RST  = 20'd1000;
   localparam logic [6:0]  GCAP_RST    = 7'd64;
   localparam logic [6:0]  UCAP_RST    = 7'd16;
   localparam logic [19:0] RECV_RST    = 20'd5000;
   localparam logic [19:0] SEND_RST    = 20'd5000;

   typedef enum logic [3:0] {
      OC_ADMITTED = 4'd0,
      OC_FULL     = 4'd1,
      OC_UNIDENT  = 4'd2,
      OC_RATE     = 4'd3,
      OC_USERCAP  = 4'd4,
      OC_PHASE    = 4'd5,
      OC_RELEASED = 4'd6,
      OC_REAPED   = 4'd7,
      OC_IGNORED  = 4'd8
   } outcome_type;

   typedef enum logic [1:0] {
      ACT_CONNECT = 2'd0,
      ACT_PHASE   = 2'd1,
      ACT_RELEASE = 2'd2,
      ACT_TICK    = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      REG_MAX_ATT = 3'd0,
      REG_WINDOW  = 3'd1,
      REG_GCAP    = 3'd2,
      REG_UCAP    = 3'd3,
      REG_RECV    = 3'd4,
      REG_SEND    = 3'd5
   } reg_index_type;

   typedef enum logic [1:0] {
      SEL_ZERO = 2'd0,
      SEL_TGT  = 2'd1,
      SEL_FREE = 2'd2,
      SEL_PEND = 2'd3
   } slot_sel_type;

   typedef struct packed {
      logic [15:0] max_att;
      logic [19:0] window;
      logic [6:0]  gcap;
      logic [6:0]  ucap;
      logic [19:0] recv;
      logic [19:0] send;
   } cfg_type;

   typedef struct packed {
      logic         capture;
      logic         lscan_start;
      logic         lscan;
      logic         lupd;
      logic         scan_start;
      logic         uscan;
      logic         tscan;
      logic         admit;
      logic         phase;
      logic         release_slot;
      logic         fin_set;
      outcome_type  fin_code;
      slot_sel_type fin_sel;
      logic         fin_load;
   } cmd_type;

   typedef struct packed {
      action_type action;
      logic       full;
      logic       ident;
      logic       lim_off;
      logic       tgt_bad;
      logic       lim_match;
      logic       li_last;
      logic       lim_ok;
      logic       lim_pass;
      logic       si_last;
      logic       ucap_hit;
      logic       free_ok;
      logic       tgo;
      logic       pend_v;
      logic       out_free;
   } status_type;

endpackage

>>> hw/rtl/cac_csr.sv
// Configuration register block with APB-style access.
`timescale 1ns / 1ps
module cac_csr (
   input  logic             clock,
   input  logic             reset,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [4:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready,
   output cac_pkg::cfg_type cfg
);
   import cac_pkg::*;

   cfg_type       cfg_ff, cfg_in;
   reg_index_type idx;

   assign idx    = reg_index_type'(paddr[4:2]);
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (psel && penable && pwrite) begin
         case (idx)
            REG_MAX_ATT: cfg_in.max_att = pwdata[15:0];
            REG_WINDOW:  cfg_in.window  = pwdata[19:0];
            REG_GCAP:    cfg_in.gcap    = pwdata[6:0];
            REG_UCAP:    cfg_in.ucap    = pwdata[6:0];
            REG_RECV:    cfg_in.recv    = pwdata[19:0];
            REG_SEND:    cfg_in.send    = pwdata[19:0];
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_MAX_ATT: prdata = {16'd0, cfg_ff.max_att};
         REG_WINDOW:  prdata = {12'd0, cfg_ff.window};
         REG_GCAP:    prdata = {25'd0, cfg_ff.gcap};
         REG_UCAP:    prdata = {25'd0, cfg_ff.ucap};
         REG_RECV:    prdata = {12'd0, cfg_ff.recv};
         REG_SEND:    prdata = {12'd0, cfg_ff.send};
         default:     prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{max_att: MAX_ATT_RST, window: WINDOW_RST, gcap: GCAP_RST,
                     ucap: UCAP_RST, recv: RECV_RST, send: SEND_RST};
      end else begin
         cfg_ff <= cfg_in;
      end
   end
endmodule

>>> hw/rtl/cac_ctrl.sv
// Sequencing state machine of the admission controller.
`timescale 1ns / 1ps
module cac_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  cac_pkg::status_type st,
   output cac_pkg::cmd_type    cmd
);
   import cac_pkg::*;

   typedef enum logic [8:0] {
      S_IDLE  = 9'b000000001,
      S_DISP  = 9'b000000010,
      S_LSCAN = 9'b000000100,
      S_LUPD  = 9'b000001000,
      S_USCAN = 9'b000010000,
      S_UEND  = 9'b000100000,
      S_TSCAN = 9'b001000000,
      S_TEND  = 9'b010000000,
      S_FIN   = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DISP;
            end
         end
         S_DISP: begin
            case (st.action)
               ACT_CONNECT: begin
                  if (st.full) begin
                     cmd.fin_set = 1'b1; cmd.fin_code = OC_FULL; cmd.fin_sel = SEL_ZERO;
                     state_in = S_FIN;
                  end else if (!st.ident) begin
                     cmd.fin_set = 1'b1; cmd.fin_code = OC_UNIDENT; cmd.fin_sel = SEL_ZERO;
                     state_in = S_FIN;
                  end else if (st.lim_off) begin
                     cmd.scan_start = 1'b1;
                     state_in       = S_USCAN;
                  end else begin
                     cmd.lscan_start = 1'b1;
                     state_in        = S_LSCAN;
                  end
               end
               ACT_PHASE, ACT_RELEASE: begin
                  cmd.fin_set = 1'b1;
                  state_in    = S_FIN;
                  if (st.tgt_bad) begin
                     cmd.fin_code = OC_IGNORED; cmd.fin_sel = SEL_ZERO;
                  end else if (st.action == ACT_PHASE) begin
                     cmd.phase = 1'b1; cmd.fin_code = OC_PHASE; cmd.fin_sel = SEL_TGT;
                  end else begin
                     cmd.release_slot = 1'b1; cmd.fin_code = OC_RELEASED;
                     cmd.fin_sel = SEL_TGT;
                  end
               end
               default: begin
                  cmd.scan_start = 1'b1;
                  state_in       = S_TSCAN;
               end
            endcase
         end
         S_LSCAN: begin
            cmd.lscan = 1'b1;
            if (st.lim_match || st.li_last) state_in = S_LUPD;
         end
         S_LUPD: begin
            if (st.lim_ok) cmd.lupd = 1'b1;
            if (st.lim_ok && st.lim_pass) begin
               cmd.scan_start = 1'b1;
               state_in       = S_USCAN;
            end else begin
               cmd.fin_set = 1'b1; cmd.fin_code = OC_RATE; cmd.fin_sel = SEL_ZERO;
               state_in = S_FIN;
            end
         end
         S_USCAN: begin
            cmd.uscan = 1'b1;
            if (st.si_last) state_in = S_UEND;
         end
         S_UEND: begin
            cmd.fin_set = 1'b1;
            state_in    = S_FIN;
            if (st.ucap_hit) begin
               cmd.fin_code = OC_USERCAP; cmd.fin_sel = SEL_ZERO;
            end else if (!st.free_ok) begin
               cmd.fin_code = OC_FULL; cmd.fin_sel = SEL_ZERO;
            end else begin
               cmd.admit = 1'b1; cmd.fin_code = OC_ADMITTED; cmd.fin_sel = SEL_FREE;
            end
         end
         S_TSCAN: begin
            cmd.tscan = 1'b1;
            if (st.tgo && st.si_last) state_in = S_TEND;
         end
         S_TEND: begin
            cmd.fin_set  = 1'b1;
            cmd.fin_code = st.pend_v ? OC_REAPED : OC_IGNORED;
            cmd.fin_sel  = st.pend_v ? SEL_PEND : SEL_ZERO;
            state_in     = S_FIN;
         end
         S_FIN: begin
            if (st.out_free) begin
               cmd.fin_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

>>> hw/rtl/cac_dp.sv
// Datapath: slot pool, attempt limiter table, scan counters and result register.
`timescale 1ns / 1ps
module cac_dp #(
   parameter int SLOT_COUNT      = cac_pkg::SLOT_COUNT_DEF,
   parameter int LIMITER_ENTRIES = cac_pkg::LIMITER_ENTRIES_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  cac_pkg::cfg_type    cfg,
   input  cac_pkg::cmd_type    cmd,
   output cac_pkg::status_type st,
   input  logic [1:0]          req_action,
   input  logic [31:0]         req_user_id,
   input  logic                req_identity_ok,
   input  logic [5:0]          req_target_slot,
   input  logic [31:0]         req_now_ms,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [3:0]          rsp_outcome,
   output logic [5:0]          rsp_slot_index,
   output logic                rsp_last
);
   import cac_pkg::*;

   localparam int SLOTS_USED = (SLOT_COUNT < SLOT_LIMIT) ? SLOT_COUNT : SLOT_LIMIT;
   localparam int SLOT_IW    = (SLOTS_USED > 1) ? $clog2(SLOTS_USED) : 1;
   localparam int LIM_IW     = (LIMITER_ENTRIES > 1) ? $clog2(LIMITER_ENTRIES) : 1;

   // captured transaction
   action_type  act_ff;
   logic [31:0] uid_ff, now_ff;
   logic        ident_ff;
   logic [5:0]  tgt_ff;

   // slot pool
   logic [SLOTS_USED-1:0] busy_ff, busy_in;
   logic [6:0]            active_ff, active_in;
   logic [31:0]           owner_mem [SLOTS_USED];
   logic [31:0]           dl_mem    [SLOTS_USED];
   logic [31:0]           owner_q, dl_q;

   // limiter table
   logic [LIMITER_ENTRIES-1:0] lv_ff;
   logic [16:0]                lcnt_ff  [LIMITER_ENTRIES];
   logic [31:0]                luser_ff [LIMITER_ENTRIES];
   logic [31:0]                lstart_ff[LIMITER_ENTRIES];
   logic [LIM_IW-1:0]          li_ff, sel_ff;
   logic                       lok_ff, lhit_ff;

   // slot scan
   logic [SLOT_IW-1:0] si_ff, si_in, free_ff, pend_ff;
   logic               free_ok_ff, pend_v_ff;
   logic [6:0]         ucnt_ff;

   // result
   outcome_type fin_code_ff;
   logic [5:0]  fin_slot_ff;
   logic        out_v_ff;
   outcome_type out_oc_ff;
   logic [5:0]  out_slot_ff;
   logic        out_last_ff;

   logic [6:0]         cap_eff;
   logic [SLOT_IW-1:0] tgt_idx;
   logic               tgt_busy, out_free, lmatch, si_last, li_last;
   logic [16:0]        cnt_old, cnt_base, cnt_new;
   logic [31:0]        start_old, start_new, left;
   logic               restart, reap, tgo, tpush;

   assign tgt_idx  = tgt_ff[SLOT_IW-1:0];
   assign tgt_busy = (32'(tgt_ff) < 32'(SLOTS_USED)) && busy_ff[tgt_idx];
   assign out_free = !out_v_ff || rsp_ready;
   assign si_last  = (si_ff == SLOT_IW'(SLOTS_USED - 1));
   assign li_last  = (li_ff == LIM_IW'(LIMITER_ENTRIES - 1));
   assign lmatch   = lv_ff[li_ff] && (luser_ff[li_ff] == uid_ff);

   always_comb begin
      cap_eff = cfg.gcap;
      if (cap_eff == 7'd0) cap_eff = 7'd1;
      if (cap_eff > 7'(SLOTS_USED)) cap_eff = 7'(SLOTS_USED);
   end

   always_comb begin
      cnt_old   = lhit_ff ? lcnt_ff[sel_ff] : 17'd0;
      start_old = lstart_ff[sel_ff];
      restart   = (cnt_old == 17'd0) || ((now_ff - start_old) > {12'd0, cfg.window});
      cnt_base  = restart ? 17'd0 : cnt_old;
      cnt_new   = (cnt_base == COUNT_MAX) ? cnt_base : cnt_base + 17'd1;
      start_new = restart ? now_ff : start_old;
   end

   assign left  = dl_q - now_ff;
   assign reap  = busy_ff[si_ff] && ((left == 32'd0) || left[31]);
   assign tgo   = !(reap && pend_v_ff && !out_free);
   assign tpush = cmd.tscan && reap && pend_v_ff && tgo;

   always_comb begin
      st.action    = act_ff;
      st.full      = (active_ff >= cap_eff);
      st.ident     = ident_ff;
      st.lim_off   = (cfg.max_att == 16'd0);
      st.tgt_bad   = !tgt_busy;
      st.lim_match = lmatch;
      st.li_last   = li_last;
      st.lim_ok    = lok_ff;
      st.lim_pass  = (cnt_new <= {1'b0, cfg.max_att});
      st.si_last   = si_last;
      st.ucap_hit  = (cfg.ucap != 7'd0) && (ucnt_ff >= cfg.ucap);
      st.free_ok   = free_ok_ff;
      st.tgo       = tgo;
      st.pend_v    = pend_v_ff;
      st.out_free  = out_free;
   end

   always_comb begin
      si_in = si_ff;
      if (cmd.scan_start) si_in = '0;
      else if ((cmd.uscan || (cmd.tscan && tgo)) && !si_last) si_in = si_ff + 1'b1;
   end

   always_comb begin
      busy_in   = busy_ff;
      active_in = active_ff;
      if (cmd.admit) begin
         busy_in[free_ff] = 1'b1;
         active_in        = active_ff + 7'd1;
      end else if (cmd.release_slot || (cmd.tscan && reap && tgo)) begin
         busy_in[cmd.release_slot ? tgt_idx : si_ff] = 1'b0;
         if (active_ff != 7'd0) active_in = active_ff - 7'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.admit) begin
         owner_mem[free_ff] <= uid_ff;
         dl_mem[free_ff]    <= now_ff + {12'd0, cfg.recv};
      end else if (cmd.phase) begin
         dl_mem[tgt_idx] <= now_ff + {12'd0, cfg.send};
      end
      owner_q <= owner_mem[si_in];
      dl_q    <= dl_mem[si_in];
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         act_ff   <= action_type'(req_action);
         uid_ff   <= req_user_id;
         ident_ff <= req_identity_ok;
         tgt_ff   <= req_target_slot;
         now_ff   <= req_now_ms;
      end
      if (cmd.lupd) begin
         luser_ff[sel_ff]  <= uid_ff;
         lstart_ff[sel_ff] <= start_new;
      end
      if (cmd.fin_set) begin
         fin_code_ff <= cmd.fin_code;
         case (cmd.fin_sel)
            SEL_TGT:  fin_slot_ff <= tgt_ff;
            SEL_FREE: fin_slot_ff <= 6'(free_ff);
            SEL_PEND: fin_slot_ff <= 6'(pend_ff);
            default:  fin_slot_ff <= 6'd0;
         endcase
      end
      if (cmd.fin_load) begin
         out_oc_ff   <= fin_code_ff;
         out_slot_ff <= fin_slot_ff;
         out_last_ff <= 1'b1;
      end else if (tpush) begin
         out_oc_ff   <= OC_REAPED;
         out_slot_ff <= 6'(pend_ff);
         out_last_ff <= 1'b0;
      end
      if (cmd.lscan_start) begin
         li_ff <= '0;
      end else if (cmd.lscan && !li_last) begin
         li_ff <= li_ff + 1'b1;
      end
      if (cmd.lscan) begin
         if (lmatch || (!lv_ff[li_ff] && !lok_ff)) sel_ff <= li_ff;
      end
      si_ff <= si_in;
      if (cmd.uscan && !busy_ff[si_ff] && !free_ok_ff) free_ff <= si_ff;
      if (cmd.tscan && reap && tgo) pend_ff <= si_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= '0;
         active_ff  <= 7'd0;
         lv_ff      <= '0;
         for (int i = 0; i < LIMITER_ENTRIES; i++) lcnt_ff[i] <= 17'd0;
         lok_ff     <= 1'b0;
         lhit_ff    <= 1'b0;
         free_ok_ff <= 1'b0;
         pend_v_ff  <= 1'b0;
         ucnt_ff    <= 7'd0;
         out_v_ff   <= 1'b0;
      end else begin
         busy_ff   <= busy_in;
         active_ff <= active_in;
         if (cmd.lupd) begin
            lv_ff[sel_ff]   <= 1'b1;
            lcnt_ff[sel_ff] <= cnt_new;
         end
         if (cmd.lscan_start) begin
            lok_ff  <= 1'b0;
            lhit_ff <= 1'b0;
         end else if (cmd.lscan) begin
            if (lmatch) begin
               lok_ff  <= 1'b1;
               lhit_ff <= 1'b1;
            end else if (!lv_ff[li_ff]) begin
               lok_ff <= 1'b1;
            end
         end
         if (cmd.scan_start) begin
            free_ok_ff <= 1'b0;
            pend_v_ff  <= 1'b0;
            ucnt_ff    <= 7'd0;
         end else begin
            if (cmd.uscan) begin
               if (!busy_ff[si_ff]) free_ok_ff <= 1'b1;
               if (busy_ff[si_ff] && (owner_q == uid_ff)) ucnt_ff <= ucnt_ff + 7'd1;
            end
            if (cmd.tscan && reap && tgo) pend_v_ff <= 1'b1;
         end
         if (cmd.fin_load || tpush) out_v_ff <= 1'b1;
         else if (rsp_ready) out_v_ff <= 1'b0;
      end
   end

   assign rsp_valid      = out_v_ff;
   assign rsp_outcome    = out_oc_ff;
   assign rsp_slot_index = out_slot_ff;
   assign rsp_last       = out_last_ff;
endmodule

>>> hw/rtl/connection_admission_controller.sv
// Top level of the connection admission controller.
//
//  channel   direction  handshake          payload
//  req_      in         req_valid/ready    action, user_id, identity_ok, target_slot, now_ms
//  rsp_      out        rsp_valid/ready    outcome, slot_index, last
//  csr       in/out     psel/penable/...   six config registers at 4*i
//
// One transaction at a time. Send phase, release and connects refused at dispatch go
// straight to the result; a connect that reaches the limiter scans up to LIMITER_ENTRIES
// table entries, then SLOTS (min of SLOT_COUNT and 64) slots for the owner scan; a tick
// scans one slot per cycle from the deadline memory, holding while a reap waits on rsp_ready.
// Synchronous reset clears slot busy bits, counts and the limiter table valid bits.
`timescale 1ns / 1ps
module connection_admission_controller #(
   parameter int SLOT_COUNT      = cac_pkg::SLOT_COUNT_DEF,
   parameter int LIMITER_ENTRIES = cac_pkg::LIMITER_ENTRIES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_action,
   input  logic [31:0] req_user_id,
   input  logic        req_identity_ok,
   input  logic [5:0]  req_target_slot,
   input  logic [31:0] req_now_ms,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_outcome,
   output logic [5:0]  rsp_slot_index,
   output logic        rsp_last,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import cac_pkg::*;

   cfg_type    cfg;
   cmd_type    cmd;
   status_type st;

   cac_csr u_csr (
      .clock(clock), .reset(reset), .psel(psel), .penable(penable), .pwrite(pwrite),
      .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
   );

   cac_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .st(st), .cmd(cmd)
   );

   cac_dp #(.SLOT_COUNT(SLOT_COUNT), .LIMITER_ENTRIES(LIMITER_ENTRIES)) u_dp (
      .clock(clock), .reset(reset), .cfg(cfg), .cmd(cmd), .st(st),
      .req_action(req_action), .req_user_id(req_user_id),
      .req_identity_ok(req_identity_ok), .req_target_slot(req_target_slot),
      .req_now_ms(req_now_ms), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_outcome(rsp_outcome), .rsp_slot_index(rsp_slot_index), .rsp_last(rsp_last)
   );

   a_oc_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_outcome <= OC_IGNORED)
      else $error("outcome code out of range");

   a_not_last_reaped: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> rsp_outcome == OC_REAPED)
      else $error("non-final result that is not a reap");

   a_slot_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_outcome == OC_FULL || rsp_outcome == OC_UNIDENT ||
       rsp_outcome == OC_RATE || rsp_outcome == OC_USERCAP ||
       rsp_outcome == OC_IGNORED)) |-> rsp_slot_index == 6'd0)
      else $error("slot index set on refusal");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second transaction taken while busy");
endmodule

>>> tb/sv/connection_admission_controller_tb.sv
// Self-checking testbench for the connection admission controller.
`timescale 1ns / 1ps
module connection_admission_controller_tb;
   import cac_pkg::*;

   localparam int NSLOT = 64;
   localparam int NLIM  = 16;
   localparam longint CYCLE_LIMIT = 2000000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_action = '0;
   logic [31:0] req_user_id = '0;
   logic        req_identity_ok = 1'b0;
   logic [5:0]  req_target_slot = '0;
   logic [31:0] req_now_ms = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [3:0]  rsp_outcome;
   logic [5:0]  rsp_slot_index;
   logic        rsp_last;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [4:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   connection_admission_controller u_dut (.*);

   typedef struct packed {
      outcome_type outcome;
      logic [5:0]  slot;
      logic        last;
   } verdict_t;

   // shadow configuration and state
   logic [15:0] max_att;
   logic [19:0] window_ms;
   logic [6:0]  gcap, ucap;
   logic [19:0] recv_ms, send_ms;
   logic        busy [NSLOT];
   logic [31:0] owner [NSLOT];
   logic [31:0] deadline [NSLOT];
   int unsigned active;
   logic        lim_v [NLIM];
   logic [31:0] lim_uid [NLIM];
   logic [16:0] lim_cnt [NLIM];
   logic [31:0] lim_start [NLIM];

   verdict_t    pending_verdicts[$];
   int          errors = 0;
   int          checked = 0;
   int          sent = 0;
   longint      cycles = 0;
   logic [31:0] clk_ms = 32'd0;

   initial begin
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("TEST FAILED");
         $finish;
      end
   end

   function automatic bit limiter_ok(logic [31:0] uid, logic [31:0] now);
      int hit;
      hit = -1;
      if (max_att == 0) return 1;
      for (int i = 0; i < NLIM; i++)
         if (hit < 0 && lim_v[i] && lim_uid[i] == uid) hit = i;
      if (hit < 0) begin
         for (int i = 0; i < NLIM; i++)
            if (hit < 0 && !lim_v[i]) hit = i;
         if (hit < 0) return 0;
         lim_v[hit] = 1;
         lim_uid[hit] = uid;
         lim_cnt[hit] = 0;
         lim_start[hit] = now;
      end
      if (lim_cnt[hit] == 0 || (now - lim_start[hit]) > {12'd0, window_ms}) begin
         lim_start[hit] = now;
         lim_cnt[hit] = 0;
      end
      if (lim_cnt[hit] != COUNT_MAX) lim_cnt[hit] = lim_cnt[hit] + 1;
      return {15'd0, lim_cnt[hit]} <= {16'd0, max_att};
   endfunction

   function automatic void predict_admission(action_type act, logic [31:0] uid,
                                             logic ident, logic [5:0] tgt,
                                             logic [31:0] now);
      int unsigned cap, n, s;
      logic [31:0] left;
      verdict_t v;
      v = '{OC_IGNORED, 6'd0, 1'b1};
      case (act)
         ACT_CONNECT: begin
            cap = gcap;
            if (cap < 1) cap = 1;
            if (cap > NSLOT) cap = NSLOT;
            if (active >= cap) v.outcome = OC_FULL;
            else if (!ident) v.outcome = OC_UNIDENT;
            else if (!limiter_ok(uid, now)) v.outcome = OC_RATE;
            else begin
               n = 0;
               for (int i = 0; i < NSLOT; i++) if (busy[i] && owner[i] == uid) n++;
               if (ucap != 0 && n >= ucap) v.outcome = OC_USERCAP;
               else begin
                  s = NSLOT;
                  for (int i = NSLOT - 1; i >= 0; i--) if (!busy[i]) s = i;
                  if (s >= NSLOT) v.outcome = OC_FULL;
                  else begin
                     busy[s] = 1;
                     owner[s] = uid;
                     deadline[s] = now + {12'd0, recv_ms};
                     active++;
                     v.outcome = OC_ADMITTED;
                     v.slot = s[5:0];
                  end
               end
            end
            pending_verdicts.push_back(v);
         end
         ACT_PHASE, ACT_RELEASE: begin
            if (busy[tgt]) begin
               v.slot = tgt;
               if (act == ACT_PHASE) begin
                  deadline[tgt] = now + {12'd0, send_ms};
                  v.outcome = OC_PHASE;
               end else begin
                  busy[tgt] = 0;
                  if (active > 0) active--;
                  v.outcome = OC_RELEASED;
               end
            end
            pending_verdicts.push_back(v);
         end
         default: begin
            n = 0;
            for (int i = 0; i < NSLOT; i++) begin
               if (busy[i]) begin
                  left = deadline[i] - now;
                  if (left == 0 || left[31]) begin
                     busy[i] = 0;
                     if (active > 0) active--;
                     if (n > 0) pending_verdicts[$].last = 1'b0;
                     pending_verdicts.push_back('{OC_REAPED, 6'(i), 1'b1});
                     n++;
                  end
               end
            end
            if (n == 0) pending_verdicts.push_back(v);
         end
      endcase
   endfunction

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_verdicts.size() == 0) begin
            $error("unexpected transaction outcome=%0d slot=%0d", rsp_outcome, rsp_slot_index);
            errors++;
         end else begin
            verdict_t e;
            e = pending_verdicts.pop_front();
            checked++;
            if (rsp_outcome !== e.outcome) begin
               $error("outcome exp %0d got %0d", e.outcome, rsp_outcome);
               errors++;
            end
            if (rsp_slot_index !== e.slot) begin
               $error("slot_index exp %0d got %0d", e.slot, rsp_slot_index);
               errors++;
            end
            if (rsp_last !== e.last) begin
               $error("last exp %0d got %0d", e.last, rsp_last);
               errors++;
            end
         end
      end
   end

   // receiver backpressure, with a calm stretch
   always @(posedge clock) begin
      if (sent >= 100 && sent < 150) rsp_ready <= 1'b1;
      else rsp_ready <= ($urandom_range(99) >= 21);
   end

   task automatic csr_write(reg_index_type idx, logic [31:0] val);
      @(posedge clock);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= 5'(idx) << 2; pwdata <= val;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      case (idx)
         REG_MAX_ATT: max_att = val[15:0];
         REG_WINDOW:  window_ms = val[19:0];
         REG_GCAP:    gcap = val[6:0];
         REG_UCAP:    ucap = val[6:0];
         REG_RECV:    recv_ms = val[19:0];
         default:     send_ms = val[19:0];
      endcase
   endtask

   task automatic send_event(action_type act, logic [31:0] uid, logic ident,
                             logic [5:0] tgt, logic [31:0] now);
      if (!(sent >= 100 && sent < 150))
         while ($urandom_range(99) < 21) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      req_valid <= 1'b1;
      req_action <= act;
      req_user_id <= uid;
      req_identity_ok <= ident;
      req_target_slot <= tgt;
      req_now_ms <= now;
      do @(posedge clock); while (!req_ready);
      predict_admission(act, uid, ident, tgt, now);
      sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (120) @(posedge clock);
   endtask

   task automatic test_directed();
      send_event(ACT_CONNECT, 32'hFFFF_FFFF, 1'b0, 6'd0, 32'd0);
      send_event(ACT_CONNECT, 32'hFFFF_FFFF, 1'b1, 6'd63, 32'hFFFF_FFF0);
      send_event(ACT_CONNECT, 32'd0, 1'b1, 6'd0, 32'd0);
      send_event(ACT_PHASE, 32'd0, 1'b0, 6'd0, 32'd10);
      send_event(ACT_PHASE, 32'd0, 1'b0, 6'd0, 32'd20);
      send_event(ACT_PHASE, 32'd0, 1'b0, 6'd63, 32'd20);
      send_event(ACT_RELEASE, 32'd0, 1'b0, 6'd40, 32'd20);
      send_event(ACT_TICK, 32'd0, 1'b0, 6'd0, 32'd100);
      send_event(ACT_TICK, 32'd0, 1'b0, 6'd0, 32'hFFFF_FFFF);
      send_event(ACT_RELEASE, 32'd0, 1'b0, 6'd0, 32'd20);
      drain();
      // tight limits: rate limiting, per-user cap, global cap
      csr_write(REG_MAX_ATT, 32'd2);
      csr_write(REG_UCAP, 32'd1);
      csr_write(REG_GCAP, 32'd0);
      csr_write(REG_WINDOW, 32'd0);
      for (int i = 0; i < 4; i++) send_event(ACT_CONNECT, 32'd7, 1'b1, 6'd0, 32'd500);
      send_event(ACT_TICK, 32'd0, 1'b0, 6'd0, 32'hF000_0000);
      for (int i = 0; i < 3; i++) send_event(ACT_CONNECT, 32'd7, 1'b1, 6'd0, 32'd501);
      drain();
   endtask

   task automatic test_table_full();
      csr_write(REG_MAX_ATT, 32'd65535);
      csr_write(REG_GCAP, 32'd127);
      csr_write(REG_UCAP, 32'd0);
      csr_write(REG_WINDOW, 32'hFFFFF);
      csr_write(REG_RECV, 32'd0);
      csr_write(REG_SEND, 32'hFFFFF);
      for (int i = 0; i < 18; i++)
         send_event(ACT_CONNECT, 32'h100 + i, 1'b1, 6'd0, 32'd1000);
      send_event(ACT_TICK, 32'd0, 1'b0, 6'd0, 32'd1000);
      drain();
   endtask

   task automatic test_random();
      logic [31:0] uid_pool [8];
      action_type  act;
      int          r;
      for (int i = 0; i < 8; i++) uid_pool[i] = (i < 7) ? 32'h100 + i : $urandom;
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               csr_write(REG_MAX_ATT, 32'd0); csr_write(REG_GCAP, 32'd64);
               csr_write(REG_UCAP, 32'd64); csr_write(REG_RECV, 32'd300);
               csr_write(REG_SEND, 32'd500);
            end
            1: begin
               csr_write(REG_MAX_ATT, 32'd3); csr_write(REG_WINDOW, 32'd200);
               csr_write(REG_GCAP, 32'd12); csr_write(REG_UCAP, 32'd3);
               csr_write(REG_RECV, 32'd150);
            end
            default: begin
               csr_write(REG_MAX_ATT, 32'd100); csr_write(REG_GCAP, 32'd64);
               csr_write(REG_UCAP, 32'd16); csr_write(REG_WINDOW, 32'd1000);
               csr_write(REG_RECV, 32'd5000); csr_write(REG_SEND, 32'd5000);
            end
         endcase
         for (int k = 0; k < 70; k++) begin
            clk_ms = clk_ms + $urandom_range(40);
            r = $urandom_range(99);
            act = (r < 50) ? ACT_CONNECT : (r < 68) ? ACT_PHASE
                : (r < 86) ? ACT_RELEASE : ACT_TICK;
            send_event(act, ($urandom_range(9) == 0) ? $urandom : uid_pool[$urandom_range(7)],
                       ($urandom_range(9) != 0), 6'($urandom_range(r < 93 ? 15 : 63)),
                       ($urandom_range(29) == 0) ? $urandom : clk_ms);
         end
         drain();
      end
   endtask

   initial begin
      max_att = MAX_ATT_RST; window_ms = WINDOW_RST; gcap = GCAP_RST;
      ucap = UCAP_RST; recv_ms = RECV_RST; send_ms = SEND_RST;
      active = 0;
      for (int i = 0; i < NSLOT; i++) busy[i] = 0;
      for (int i = 0; i < NLIM; i++) begin lim_v[i] = 0; lim_cnt[i] = 0; end
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_table_full();
      test_random();
      $display("covered %0d transactions, %0d results checked", sent, checked);
      $display("limiter, caps, send phase, release and reaping across several settings");
      if (errors == 0 && pending_verdicts.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

>>> sim.f
hw/rtl/cac_pkg.sv
hw/rtl/cac_csr.sv
hw/rtl/cac_ctrl.sv
hw/rtl/cac_dp.sv
hw/rtl/connection_admission_controller.sv
tb/sv/connection_admission_controller_tb.sv
